// ===== rtl/core/lpm6_pkg.sv =====
// shared types, codes and defaults for the ipv6 multibit trie lookup engine
// no dependencies
package lpm6_pkg;

  localparam int WIDE_LEVELS_DEF  = 3;
  localparam int WIDE_NODES_DEF   = 8;
  localparam int NARROW_NODES_DEF = 1024;
  localparam int WIDE_SPAN        = 65536;
  localparam int NARROW_SPAN      = 256;
  localparam int MAX_PREFIX       = 128;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_NO_NODE = 2'd2;

  localparam logic [1:0] REG_LOOKUP_EN = 2'd0;
  localparam logic [1:0] REG_ROOT      = 2'd1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD    = 1'b1;

  typedef struct packed {
    logic [31:0] hop;
    logic [19:0] child;
    logic        valid;
    logic        wflag;
  } wide_ent_t;

  typedef struct packed {
    logic [31:0] hop;
    logic [19:0] child;
    logic        valid;
  } narrow_ent_t;

  typedef struct packed {
    logic wide_rd;
    logic wide_we;
    logic narrow_rd;
    logic narrow_we;
  } tbl_ctl_t;

  function automatic logic [7:0] addr_byte(input logic [127:0] a, input logic [3:0] k);
    logic [127:0] s;
    s = a >> (7'd120 - {k, 3'b000});
    return s[7:0];
  endfunction

endpackage

// ===== rtl/core/lpm6_tables.sv =====
// wide and narrow trie node memories with the clearing sweep after reset
// depends on lpm6_pkg
module lpm6_tables import lpm6_pkg::*; #(
  parameter int WIDE_NODES   = WIDE_NODES_DEF,
  parameter int NARROW_NODES = NARROW_NODES_DEF,
  parameter int WA_W         = $clog2(WIDE_NODES * WIDE_SPAN),
  parameter int NA_W         = $clog2(NARROW_NODES * NARROW_SPAN)
) (
  input  logic            clk,
  input  logic            rst,
  input  tbl_ctl_t        ctl,
  input  logic [WA_W-1:0] wide_addr,
  input  wide_ent_t       wide_wdata,
  output wide_ent_t       wide_rdata,
  input  logic [NA_W-1:0] narrow_addr,
  input  narrow_ent_t     narrow_wdata,
  output narrow_ent_t     narrow_rdata,
  output logic            clearing
);

  localparam int WDEPTH = WIDE_NODES * WIDE_SPAN;
  localparam int NDEPTH = NARROW_NODES * NARROW_SPAN;
  localparam int CDEPTH = (WDEPTH > NDEPTH) ? WDEPTH : NDEPTH;
  localparam int CL_W   = $clog2(CDEPTH);

  wide_ent_t   wide_mem   [WDEPTH];
  narrow_ent_t narrow_mem [NDEPTH];
  logic [CL_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == CL_W'(CDEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({1'b0, clr_idx} < (CL_W+1)'(WDEPTH)) begin
        wide_mem[clr_idx[WA_W-1:0]] <= '0;
      end
    end else if (ctl.wide_we) begin
      wide_mem[wide_addr] <= wide_wdata;
    end
    if (ctl.wide_rd) begin
      wide_rdata <= wide_mem[wide_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({1'b0, clr_idx} < (CL_W+1)'(NDEPTH)) begin
        narrow_mem[clr_idx[NA_W-1:0]] <= '0;
      end
    end else if (ctl.narrow_we) begin
      narrow_mem[narrow_addr] <= narrow_wdata;
    end
    if (ctl.narrow_rd) begin
      narrow_rdata <= narrow_mem[narrow_addr];
    end
  end

endmodule

// ===== rtl/core/ipv6_wide_stride_lpm_engine_core.sv =====
// ipv6 longest prefix match engine: sequencer that walks and updates the trie
// depends on lpm6_pkg and lpm6_tables
//
//   channel   signals                                         transfer
//   request   start, busy, req_type, addr_hi, addr_lo,        start && !busy
//             prefix_length, hop_value
//   result    done, result_hop, found, status, prefix_total   done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//
// a lookup reads the trie one level at a time (one memory port): a read state, then a check state
// an add walks the levels the same way, then reads and rewrites in turn each entry
// covered by a partial stride, the most for a short wide prefix
// after reset both tables are swept one entry a cycle, over the depth of the larger
// table, with busy high; config writes are taken throughout
// the receiver cannot stall: each result is shown for one cycle with done
module ipv6_wide_stride_lpm_engine_core import lpm6_pkg::*; #(
  parameter int WIDE_LEVELS  = WIDE_LEVELS_DEF,
  parameter int WIDE_NODES   = WIDE_NODES_DEF,
  parameter int NARROW_NODES = NARROW_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  prefix_length,
  input  logic [31:0] hop_value,
  output logic        done,
  output logic [31:0] result_hop,
  output logic        found,
  output logic [1:0]  status,
  output logic [31:0] prefix_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int WA_W = $clog2(WIDE_NODES * WIDE_SPAN);
  localparam int NA_W = $clog2(NARROW_NODES * NARROW_SPAN);
  localparam int WF_W = $clog2(WIDE_NODES + 1);
  localparam int NF_W = $clog2(NARROW_NODES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WSTEP = 4'd1;
  localparam logic [3:0] S_WCHK = 4'd2;
  localparam logic [3:0] S_WFRD = 4'd3;
  localparam logic [3:0] S_WFWR = 4'd4;
  localparam logic [3:0] S_NSTEP = 4'd5;
  localparam logic [3:0] S_NCHK = 4'd6;
  localparam logic [3:0] S_NFRD = 4'd7;
  localparam logic [3:0] S_NFWR = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]      state, state_next;
  logic            req_add, req_add_next;
  logic [127:0]    addr_q, addr_q_next;
  logic [7:0]      len, len_next;
  logic [31:0]     hop_in, hop_in_next;
  logic [19:0]     node, node_next;
  logic [1:0]      lvl, lvl_next;
  logic            wide_f, wide_f_next;
  logic [4:0]      bp, bp_next;
  logic [7:0]      depth, depth_next;
  logic [31:0]     best, best_next;
  logic            found_r, found_r_next;
  logic [1:0]      status_r, status_r_next;
  logic [15:0]     fill_idx, fill_idx_next;
  logic [15:0]     fill_last, fill_last_next;
  logic            default_valid, default_valid_next;
  logic [31:0]     default_hop, default_hop_next;
  logic [WF_W-1:0] nfw, nfw_next;
  logic [NF_W-1:0] nfn, nfn_next;
  logic [31:0]     prefix_counter, prefix_counter_next;
  logic            lookup_enable;
  logic [2:0]      root_wide_node;

  tbl_ctl_t        ctl;
  logic [WA_W-1:0] wide_addr;
  logic [NA_W-1:0] narrow_addr;
  wide_ent_t       wide_wdata, wide_rdata;
  narrow_ent_t     narrow_wdata, narrow_rdata;
  logic            clearing;

  logic [15:0] widx;
  logic [7:0]  nbyte;
  logic [7:0]  rem;
  logic [15:0] wmask;
  logic [7:0]  nmask;
  logic        wide_ok, narrow_ok, fill_w, fill_n;

  lpm6_tables #(
    .WIDE_NODES  (WIDE_NODES),
    .NARROW_NODES(NARROW_NODES),
    .WA_W        (WA_W),
    .NA_W        (NA_W)
  ) u_tables (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .wide_addr   (wide_addr),
    .wide_wdata  (wide_wdata),
    .wide_rdata  (wide_rdata),
    .narrow_addr (narrow_addr),
    .narrow_wdata(narrow_wdata),
    .narrow_rdata(narrow_rdata),
    .clearing    (clearing)
  );

  assign busy         = clearing || (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign done         = (state == S_DONE);
  assign result_hop   = best;
  assign found        = found_r;
  assign status       = status_r;
  assign prefix_total = prefix_counter;

  assign widx  = {addr_byte(addr_q, {1'b0, lvl, 1'b0}), addr_byte(addr_q, {1'b0, lvl, 1'b1})};
  assign nbyte = addr_byte(addr_q, req_add ? depth[6:3] : bp[3:0]);
  assign rem   = len - depth;
  assign wmask = 16'hFFFF >> rem[3:0];
  assign nmask = 8'hFF >> rem[2:0];
  assign fill_w = (state == S_WFRD) || (state == S_WFWR);
  assign fill_n = (state == S_NFRD) || (state == S_NFWR);
  assign wide_ok   = {1'b0, node} < 21'(WIDE_NODES);
  assign narrow_ok = (node != 20'd0) && ({1'b0, node} < 21'(NARROW_NODES));
  assign wide_addr   = WA_W'({node, fill_w ? fill_idx : widx});
  assign narrow_addr = NA_W'({node, fill_n ? fill_idx[7:0] : nbyte});

  always_comb begin
    state_next          = state;
    req_add_next        = req_add;
    addr_q_next         = addr_q;
    len_next            = len;
    hop_in_next         = hop_in;
    node_next           = node;
    lvl_next            = lvl;
    wide_f_next         = wide_f;
    bp_next             = bp;
    depth_next          = depth;
    best_next           = best;
    found_r_next        = found_r;
    status_r_next       = status_r;
    fill_idx_next       = fill_idx;
    fill_last_next      = fill_last;
    default_valid_next  = default_valid;
    default_hop_next    = default_hop;
    nfw_next            = nfw;
    nfn_next            = nfn;
    prefix_counter_next = prefix_counter;
    ctl                 = '0;
    wide_wdata          = '0;
    narrow_wdata        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          addr_q_next   = {addr_hi, addr_lo};
          req_add_next  = req_type;
          len_next      = prefix_length;
          hop_in_next   = hop_value;
          node_next     = 20'(root_wide_node);
          lvl_next      = '0;
          wide_f_next   = 1'b1;
          depth_next    = '0;
          bp_next       = 5'(2 * WIDE_LEVELS);
          status_r_next = ST_OK;
          best_next     = '0;
          found_r_next  = 1'b0;
          if (req_type == REQ_LOOKUP) begin
            if (lookup_enable && default_valid) begin
              best_next    = default_hop;
              found_r_next = 1'b1;
            end
            state_next = lookup_enable ? S_WSTEP : S_DONE;
          end else if (prefix_length > 8'(MAX_PREFIX)) begin
            status_r_next = ST_BAD_LEN;
            state_next    = S_DONE;
          end else if (prefix_length == 8'd0) begin
            default_valid_next  = 1'b1;
            default_hop_next    = hop_value;
            prefix_counter_next = prefix_counter + 32'd1;
            state_next          = S_DONE;
          end else begin
            state_next = S_WSTEP;
          end
        end
      end
      S_WSTEP: begin
        if (lvl == 2'(WIDE_LEVELS) || (req_add ? (depth >= len) : !wide_f)) begin
          state_next = S_NSTEP;
        end else if (!wide_ok) begin
          if (req_add) status_r_next = ST_NO_NODE;
          state_next = S_DONE;
        end else begin
          ctl.wide_rd = 1'b1;
          state_next  = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!req_add) begin
          if (wide_rdata.valid) begin
            best_next    = wide_rdata.hop;
            found_r_next = 1'b1;
          end
          if (wide_rdata.child == 20'd0 && !wide_rdata.wflag) begin
            state_next = S_DONE;
          end else begin
            wide_f_next = wide_rdata.wflag;
            node_next   = wide_rdata.child;
            lvl_next    = lvl + 2'd1;
            state_next  = S_WSTEP;
          end
        end else if ({1'b0, depth} + 9'd16 > {1'b0, len}) begin
          fill_idx_next  = widx & ~wmask;
          fill_last_next = widx | wmask;
          state_next     = S_WFRD;
        end else if ({1'b0, depth} + 9'd16 == {1'b0, len}) begin
          ctl.wide_we         = 1'b1;
          wide_wdata          = '{hop: hop_in, child: wide_rdata.child, valid: 1'b1,
                                  wflag: wide_rdata.wflag};
          prefix_counter_next = prefix_counter + 32'd1;
          state_next          = S_DONE;
        end else if (wide_rdata.child != 20'd0) begin
          node_next  = wide_rdata.child;
          depth_next = depth + 8'd16;
          lvl_next   = lvl + 2'd1;
          state_next = S_WSTEP;
        end else if ({1'b0, lvl} + 3'd1 < 3'(WIDE_LEVELS)) begin
          if (nfw >= WF_W'(WIDE_NODES)) begin
            status_r_next = ST_NO_NODE;
            state_next    = S_DONE;
          end else begin
            ctl.wide_we = 1'b1;
            wide_wdata  = '{hop: wide_rdata.hop, child: 20'(nfw), valid: wide_rdata.valid,
                            wflag: 1'b1};
            nfw_next    = nfw + 1'b1;
            node_next   = 20'(nfw);
            depth_next  = depth + 8'd16;
            lvl_next    = lvl + 2'd1;
            state_next  = S_WSTEP;
          end
        end else begin
          if (nfn >= NF_W'(NARROW_NODES)) begin
            status_r_next = ST_NO_NODE;
            state_next    = S_DONE;
          end else begin
            ctl.wide_we = 1'b1;
            wide_wdata  = '{hop: wide_rdata.hop, child: 20'(nfn), valid: wide_rdata.valid,
                            wflag: 1'b0};
            nfn_next    = nfn + 1'b1;
            node_next   = 20'(nfn);
            depth_next  = depth + 8'd16;
            lvl_next    = lvl + 2'd1;
            state_next  = S_WSTEP;
          end
        end
      end
      S_WFRD: begin
        ctl.wide_rd = 1'b1;
        state_next  = S_WFWR;
      end
      S_WFWR: begin
        ctl.wide_we = 1'b1;
        wide_wdata  = '{hop: hop_in, child: wide_rdata.child, valid: 1'b1,
                        wflag: wide_rdata.wflag};
        if (fill_idx == fill_last) begin
          prefix_counter_next = prefix_counter + 32'd1;
          state_next          = S_DONE;
        end else begin
          fill_idx_next = fill_idx + 16'd1;
          state_next    = S_WFRD;
        end
      end
      S_NSTEP: begin
        if (!req_add) begin
          if (bp == 5'd16 || !narrow_ok) begin
            state_next = S_DONE;
          end else begin
            ctl.narrow_rd = 1'b1;
            state_next    = S_NCHK;
          end
        end else if (depth >= len) begin
          prefix_counter_next = prefix_counter + 32'd1;
          state_next          = S_DONE;
        end else if (!narrow_ok) begin
          status_r_next = ST_NO_NODE;
          state_next    = S_DONE;
        end else begin
          ctl.narrow_rd = 1'b1;
          state_next    = S_NCHK;
        end
      end
      S_NCHK: begin
        if (!req_add) begin
          if (narrow_rdata.valid) begin
            best_next    = narrow_rdata.hop;
            found_r_next = 1'b1;
          end
          node_next = narrow_rdata.child;
          if (narrow_rdata.child == 20'd0) begin
            state_next = S_DONE;
          end else begin
            bp_next    = bp + 5'd1;
            state_next = S_NSTEP;
          end
        end else if ({1'b0, depth} + 9'd8 > {1'b0, len}) begin
          fill_idx_next  = {8'd0, nbyte & ~nmask};
          fill_last_next = {8'd0, nbyte | nmask};
          state_next     = S_NFRD;
        end else if ({1'b0, depth} + 9'd8 == {1'b0, len}) begin
          ctl.narrow_we       = 1'b1;
          narrow_wdata        = '{hop: hop_in, child: narrow_rdata.child, valid: 1'b1};
          prefix_counter_next = prefix_counter + 32'd1;
          state_next          = S_DONE;
        end else if (narrow_rdata.child != 20'd0) begin
          node_next  = narrow_rdata.child;
          depth_next = depth + 8'd8;
          state_next = S_NSTEP;
        end else if (nfn >= NF_W'(NARROW_NODES)) begin
          status_r_next = ST_NO_NODE;
          state_next    = S_DONE;
        end else begin
          ctl.narrow_we = 1'b1;
          narrow_wdata  = '{hop: narrow_rdata.hop, child: 20'(nfn),
                            valid: narrow_rdata.valid};
          nfn_next      = nfn + 1'b1;
          node_next     = 20'(nfn);
          depth_next    = depth + 8'd8;
          state_next    = S_NSTEP;
        end
      end
      S_NFRD: begin
        ctl.narrow_rd = 1'b1;
        state_next    = S_NFWR;
      end
      S_NFWR: begin
        ctl.narrow_we = 1'b1;
        narrow_wdata  = '{hop: hop_in, child: narrow_rdata.child, valid: 1'b1};
        if (fill_idx == fill_last) begin
          prefix_counter_next = prefix_counter + 32'd1;
          state_next          = S_DONE;
        end else begin
          fill_idx_next = fill_idx + 16'd1;
          state_next    = S_NFRD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      default_valid  <= 1'b0;
      default_hop    <= '0;
      nfw            <= WF_W'(1);
      nfn            <= NF_W'(1);
      prefix_counter <= '0;
      lookup_enable  <= 1'b1;
      root_wide_node <= '0;
    end else begin
      state          <= state_next;
      default_valid  <= default_valid_next;
      default_hop    <= default_hop_next;
      nfw            <= nfw_next;
      nfn            <= nfn_next;
      prefix_counter <= prefix_counter_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOOKUP_EN: lookup_enable  <= cfg_data[0];
          REG_ROOT:      root_wide_node <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_add   <= req_add_next;
    addr_q    <= addr_q_next;
    len       <= len_next;
    hop_in    <= hop_in_next;
    node      <= node_next;
    lvl       <= lvl_next;
    wide_f    <= wide_f_next;
    bp        <= bp_next;
    depth     <= depth_next;
    best      <= best_next;
    found_r   <= found_r_next;
    status_r  <= status_r_next;
    fill_idx  <= fill_idx_next;
    fill_last <= fill_last_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for more than one cycle");

  a_lookup_no_write: assert property (@(posedge clk) disable iff (rst)
    (!req_add && state != S_IDLE) |-> !(ctl.wide_we || ctl.narrow_we))
    else $error("table write during a lookup");

  a_wide_pool: assert property (@(posedge clk) disable iff (rst)
    nfw <= WF_W'(WIDE_NODES)) else $error("wide allocator past pool");

  a_narrow_pool: assert property (@(posedge clk) disable iff (rst)
    nfn <= NF_W'(NARROW_NODES)) else $error("narrow allocator past pool");

endmodule

// ===== tb/tb_ipv6_wide_stride_lpm_engine_core.sv =====
// self-checking testbench for the ipv6 multibit trie longest prefix match engine
// depends on lpm6_pkg and ipv6_wide_stride_lpm_engine_core; predicts each result with a trie
// model of its own, drives lookup and add requests with random gaps and checks every result
module tb_ipv6_wide_stride_lpm_engine_core;
  import lpm6_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WIDE   = WIDE_NODES_DEF;
  localparam int NUM_NARROW = NARROW_NODES_DEF;
  localparam int WLEVELS    = WIDE_LEVELS_DEF;

  typedef struct {
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  len;
    logic [31:0] hop;
  } route_req_t;

  typedef struct {
    logic [31:0] hop;
    logic        found;
    logic [1:0]  status;
    logic [31:0] total;
  } route_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_LOOKUP;
  logic [63:0] addr_hi = '0;
  logic [63:0] addr_lo = '0;
  logic [7:0]  prefix_length = '0;
  logic [31:0] hop_value = '0;
  logic        done;
  logic [31:0] result_hop;
  logic        found;
  logic [1:0]  status;
  logic [31:0] prefix_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_LOOKUP_EN;
  logic [7:0]  cfg_data = '0;

  ipv6_wide_stride_lpm_engine_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trie model state
  wide_ent_t   wide_tab[int];
  narrow_ent_t narrow_tab[int];
  logic        dflt_valid;
  logic [31:0] dflt_hop;
  int          free_wide, free_narrow;
  logic [31:0] add_count;
  logic        lk_enable;
  logic [2:0]  root_node;

  route_req_t  pending_reqs[$];
  route_res_t  expected_results[$];
  int          mismatch_count = 0;
  int          n_lookup = 0, n_add = 0, n_hit = 0, n_bad = 0, n_full = 0;
  logic [127:0] addr_pool[6];

  function automatic logic [7:0] byte_at(logic [127:0] a, int k);
    return a[127 - 8*k -: 8];
  endfunction

  function automatic wide_ent_t wide_rd(int e);
    return wide_tab.exists(e) ? wide_tab[e] : '0;
  endfunction

  function automatic narrow_ent_t narrow_rd(int e);
    return narrow_tab.exists(e) ? narrow_tab[e] : '0;
  endfunction

  function automatic route_res_t trie_lookup(logic [127:0] a);
    route_res_t r;
    int node, e;
    logic is_wide, stop;
    wide_ent_t w;
    narrow_ent_t n;
    r = '{hop: '0, found: 1'b0, status: ST_OK, total: add_count};
    if (!lk_enable) return r;
    if (dflt_valid) begin
      r.hop = dflt_hop;
      r.found = 1'b1;
    end
    node = root_node;
    is_wide = 1'b1;
    stop = 1'b0;
    for (int lvl = 0; lvl < WLEVELS && !stop; lvl++) begin
      if (!is_wide) break;
      if (node >= NUM_WIDE) begin
        stop = 1'b1;
        break;
      end
      e = node * WIDE_SPAN + {byte_at(a, 2*lvl), byte_at(a, 2*lvl + 1)};
      w = wide_rd(e);
      if (w.valid) begin
        r.hop = w.hop;
        r.found = 1'b1;
      end
      if (w.child == 0 && !w.wflag) begin
        stop = 1'b1;
        break;
      end
      is_wide = w.wflag;
      node = w.child;
    end
    if (!stop) begin
      for (int b = 2*WLEVELS; b < 16; b++) begin
        if (node == 0 || node >= NUM_NARROW) break;
        e = node * NARROW_SPAN + byte_at(a, b);
        n = narrow_rd(e);
        if (n.valid) begin
          r.hop = n.hop;
          r.found = 1'b1;
        end
        node = n.child;
        if (node == 0) break;
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] trie_add(logic [127:0] a, int len, logic [31:0] hop);
    int node, depth, idx, cnt, base, child;
    wide_ent_t w;
    narrow_ent_t n;
    node = root_node;
    depth = 0;
    if (len > MAX_PREFIX) return ST_BAD_LEN;
    if (len == 0) begin
      dflt_valid = 1'b1;
      dflt_hop = hop;
      add_count++;
      return ST_OK;
    end
    for (int lvl = 0; lvl < WLEVELS && depth < len; lvl++) begin
      if (node >= NUM_WIDE) return ST_NO_NODE;
      base = node * WIDE_SPAN;
      idx = {byte_at(a, 2*lvl), byte_at(a, 2*lvl + 1)};
      if (depth + 16 >= len) begin
        cnt = 1 << (16 - (len - depth));
        idx = idx & ~(cnt - 1) & 16'hffff;
        for (int i = 0; i < cnt; i++) begin
          w = wide_rd(base + idx + i);
          w.valid = 1'b1;
          w.hop = hop;
          wide_tab[base + idx + i] = w;
        end
        add_count++;
        return ST_OK;
      end
      w = wide_rd(base + idx);
      child = w.child;
      if (child == 0) begin
        if (lvl + 1 < WLEVELS) begin
          if (free_wide >= NUM_WIDE) return ST_NO_NODE;
          child = free_wide++;
          w.wflag = 1'b1;
        end else begin
          if (free_narrow >= NUM_NARROW) return ST_NO_NODE;
          child = free_narrow++;
          w.wflag = 1'b0;
        end
        w.child = child;
        wide_tab[base + idx] = w;
      end
      node = child;
      depth += 16;
    end
    while (depth < len) begin
      if (node == 0 || node >= NUM_NARROW) return ST_NO_NODE;
      base = node * NARROW_SPAN;
      idx = byte_at(a, depth / 8);
      if (depth + 8 >= len) begin
        cnt = 1 << (8 - (len - depth));
        idx = idx & ~(cnt - 1) & 8'hff;
        for (int i = 0; i < cnt; i++) begin
          n = narrow_rd(base + idx + i);
          n.valid = 1'b1;
          n.hop = hop;
          narrow_tab[base + idx + i] = n;
        end
        add_count++;
        return ST_OK;
      end
      n = narrow_rd(base + idx);
      child = n.child;
      if (child == 0) begin
        if (free_narrow >= NUM_NARROW) return ST_NO_NODE;
        child = free_narrow++;
        n.child = child;
        narrow_tab[base + idx] = n;
      end
      node = child;
      depth += 8;
    end
    add_count++;
    return ST_OK;
  endfunction

  function automatic route_res_t trie_step(route_req_t q);
    route_res_t r;
    if (q.kind == REQ_LOOKUP) begin
      r = trie_lookup({q.hi, q.lo});
      n_lookup++;
      if (r.found) n_hit++;
    end else begin
      r.status = trie_add({q.hi, q.lo}, q.len, q.hop);
      r.hop = '0;
      r.found = 1'b0;
      r.total = add_count;
      n_add++;
      if (r.status == ST_BAD_LEN) n_bad++;
      if (r.status == ST_NO_NODE) n_full++;
    end
    return r;
  endfunction

  // driver
  int   gap_left = 0;
  logic gap_burst = 1'b0;
  route_req_t cur_req;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(trie_step(cur_req));
      start <= 1'b0;
      if ($urandom_range(0, 40) == 0) gap_burst <= ~gap_burst;
      gap_left <= gap_burst ? 0 : $urandom_range(0, 16);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_type <= cur_req.kind;
        addr_hi <= cur_req.hi;
        addr_lo <= cur_req.lo;
        prefix_length <= cur_req.len;
        hop_value <= cur_req.hop;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    route_res_t ex;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result hop=%h found=%b status=%0d total=%0d",
                   result_hop, found, status, prefix_total);
      end else begin
        ex = expected_results.pop_front();
        if (result_hop !== ex.hop || found !== ex.found || status !== ex.status ||
            prefix_total !== ex.total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp hop=%h found=%b status=%0d total=%0d, ",
                      "got hop=%h found=%b status=%0d total=%0d"},
                     ex.hop, ex.found, ex.status, ex.total,
                     result_hop, found, status, prefix_total);
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LOOKUP_EN) lk_enable = val[0];
    else if (idx == REG_ROOT) root_node = val[2:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_req(logic kind, logic [127:0] a, int len, logic [31:0] hop);
    pending_reqs.push_back('{kind: kind, hi: a[127:64], lo: a[63:0], len: len[7:0], hop: hop});
  endtask

  function automatic logic [127:0] pick_addr();
    logic [127:0] a, m;
    int cut;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom, $urandom, $urandom};
    a = addr_pool[$urandom_range(0, 5)];
    m = {$urandom, $urandom, $urandom, $urandom};
    cut = $urandom_range(2, 16);
    for (int k = cut; k < 16; k++) a[127 - 8*k -: 8] = m[127 - 8*k -: 8];
    return a;
  endfunction

  function automatic int pick_len();
    int r, len;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(129, 255);
    if (r < 12) return 0;
    if (r < 30) return 8 * $urandom_range(2, 16);
    len = $urandom_range(8, 128);
    if (len < 48 && len % 16 != 0 && len % 16 < 8) len = len | 8;
    return len;
  endfunction

  task automatic random_phase(int cnt);
    logic [127:0] a;
    for (int i = 0; i < cnt; i++) begin
      a = pick_addr();
      if ($urandom_range(0, 9) < 4) push_req(REQ_ADD, a, pick_len(), $urandom);
      else push_req(REQ_LOOKUP, a, $urandom_range(0, 255), $urandom);
    end
    wait_idle();
  endtask

  initial begin
    logic [127:0] a0;
    dflt_valid = 1'b0;
    dflt_hop = '0;
    free_wide = 1;
    free_narrow = 1;
    add_count = '0;
    lk_enable = 1'b1;
    root_node = '0;
    foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    cfg_write(REG_LOOKUP_EN, 8'h01);
    cfg_write(REG_ROOT, 8'h00);

    a0 = addr_pool[0];
    push_req(REQ_LOOKUP, a0, 0, '0);
    push_req(REQ_ADD, '0, 0, 32'hffffffff);
    push_req(REQ_LOOKUP, '1, 0, '0);
    push_req(REQ_ADD, a0, 16, 32'h11111111);
    push_req(REQ_ADD, a0, 32, 32'h22222222);
    push_req(REQ_ADD, a0, 48, 32'h33333333);
    push_req(REQ_ADD, a0, 56, 32'h44444444);
    push_req(REQ_ADD, a0, 128, 32'h0);
    push_req(REQ_ADD, a0, 52, 32'h55555555);
    push_req(REQ_ADD, a0, 20, 32'h66666666);
    push_req(REQ_ADD, a0, 129, 32'h77777777);
    push_req(REQ_ADD, a0, 255, 32'h88888888);
    push_req(REQ_ADD, '1, 128, 32'h99999999);
    push_req(REQ_ADD, '1, 8, 32'haaaaaaaa);
    push_req(REQ_ADD, '0, 1, 32'hbbbbbbbb);
    push_req(REQ_LOOKUP, a0, 0, '0);
    push_req(REQ_LOOKUP, a0 ^ 128'h1, 0, '0);
    push_req(REQ_LOOKUP, a0 ^ {56'h0, 8'hff, 64'h0}, 0, '0);
    push_req(REQ_LOOKUP, '1, 0, '0);
    push_req(REQ_LOOKUP, '0, 0, '0);
    push_req(REQ_LOOKUP, 128'h7fff << 112, 0, '0);
    wait_idle();

    random_phase(500);
    cfg_write(REG_LOOKUP_EN, 8'h00);
    random_phase(100);
    cfg_write(REG_LOOKUP_EN, 8'hff);
    cfg_write(REG_ROOT, 8'hff);
    random_phase(300);
    cfg_write(2'd2, 8'h5a);
    cfg_write(2'd3, 8'ha5);
    cfg_write(REG_ROOT, 8'h01);
    random_phase(250);

    $display("covered %0d lookups (%0d matched) and %0d adds (%0d bad length, %0d out of nodes)",
             n_lookup, n_hit, n_add, n_bad, n_full);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== ipv6_wide_stride_lpm_engine_core.f =====
rtl/core/lpm6_pkg.sv
rtl/core/lpm6_tables.sv
rtl/core/ipv6_wide_stride_lpm_engine_core.sv
tb/tb_ipv6_wide_stride_lpm_engine_core.sv
